/* src/grid_plane_interpolator_core_assert.svh */
// Assertion macros shared by the grid plane interpolator modules.
`ifndef GRID_PLANE_INTERPOLATOR_CORE_ASSERT_SVH
`define GRID_PLANE_INTERPOLATOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define GPI_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define GPI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define GPI_ASSERT_IMPL(label, ante, cons)
`define GPI_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* src/gpi_pkg.sv */
// Shared constants, command codes and controller/datapath interface types.
package gpi_pkg;

  localparam int GRID_POINTS = 64;
  localparam int IDX_W       = $clog2(GRID_POINTS);
  localparam int CNT_W       = IDX_W + 1;
  localparam int DATA_W      = 32;
  localparam int FRAC_BITS   = 16;
  localparam int DIV_W       = DATA_W + 1 + FRAC_BITS;
  localparam int DCNT_W      = 6;
  localparam int TERM_W      = 42;
  localparam int SUM_W       = 44;
  localparam int PROD_W      = 65;

  typedef enum logic [1:0] {
    CMD_WR_ABS  = 2'd0,
    CMD_WR_GRID = 2'd1,
    CMD_QUERY   = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BELOW  = 2'd1,
    ST_ZERO_D = 2'd2
  } status_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_WR_ABS,
    OP_WR_GRID,
    OP_LOAD,
    OP_SRCH_RD,
    OP_SRCH_SAVE,
    OP_RD_A0,
    OP_RD_A1,
    OP_RD_AXL,
    OP_RD_AYL,
    OP_RD_F00,
    OP_RD_FX1,
    OP_RD_FY1,
    OP_DIV_START,
    OP_DIV_STEP,
    OP_SAT,
    OP_MUL,
    OP_TERM,
    OP_SUM,
    OP_FINISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t  op;
    logic    axis;
    status_t code;
  } dp_cmd_t;

  typedef struct packed {
    logic srch_done;
    logic srch_axis;
    logic below;
    logic zero_d;
    logic div_done;
  } dp_stat_t;

endpackage

/* src/grid_plane_interpolator_core.sv */
// Top level: planar grid interpolator, controller plus datapath.
// Writes keep the controller idle, so the next item can be accepted in the following cycle.
// A query runs two binary searches of up to 7 probes each, seven table reads,
// and two 49-step restoring divisions on one shared divider.
// Queries below the first abscissa finish after the searches.
// rst_n is synchronous, active low; it clears control state and sets the configured point count to 64.
module grid_plane_interpolator_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [gpi_pkg::CNT_W-1:0]         cfg_wr_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_cmd,
  input  logic [gpi_pkg::IDX_W-1:0]         in_index_row,
  input  logic [gpi_pkg::IDX_W-1:0]         in_index_col,
  input  logic signed [gpi_pkg::DATA_W-1:0] in_write_value,
  input  logic signed [gpi_pkg::DATA_W-1:0] in_query_x,
  input  logic signed [gpi_pkg::DATA_W-1:0] in_query_y,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [gpi_pkg::DATA_W-1:0] out_interpolated,
  output logic [1:0]                        out_status
);
  import gpi_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  gpi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_cmd    (in_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  gpi_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_index_row     (in_index_row),
    .in_index_col     (in_index_col),
    .in_write_value   (in_write_value),
    .in_query_x       (in_query_x),
    .in_query_y       (in_query_y),
    .cmd              (cmd),
    .stat             (stat),
    .out_interpolated (out_interpolated),
    .out_status       (out_status)
  );

endmodule

/* src/gpi_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module gpi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* src/gpi_dp.sv */
// Datapath: tables, binary search, serial divider, multiplier and result register.
`include "grid_plane_interpolator_core_assert.svh"
module gpi_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [gpi_pkg::CNT_W-1:0]         cfg_wr_data,
  input  logic [gpi_pkg::IDX_W-1:0]         in_index_row,
  input  logic [gpi_pkg::IDX_W-1:0]         in_index_col,
  input  logic signed [gpi_pkg::DATA_W-1:0] in_write_value,
  input  logic signed [gpi_pkg::DATA_W-1:0] in_query_x,
  input  logic signed [gpi_pkg::DATA_W-1:0] in_query_y,
  input  gpi_pkg::dp_cmd_t                  cmd,
  output gpi_pkg::dp_stat_t                 stat,
  output logic signed [gpi_pkg::DATA_W-1:0] out_interpolated,
  output logic [1:0]                        out_status
);
  import gpi_pkg::*;

  localparam logic signed [DATA_W:0]   D0       = '0;
  localparam logic [DIV_W-1:0]         POS_LIM  = DIV_W'(32'h7FFF_FFFF);
  localparam logic [DIV_W-1:0]         NEG_LIM  = DIV_W'(33'h1_0000_0000) >> 1;
  localparam logic signed [PROD_W-1:0] TLIM     = PROD_W'(41'h100_0000_0000);
  localparam logic signed [SUM_W-1:0]  SMAX     = SUM_W'(32'h7FFF_FFFF);
  localparam logic signed [SUM_W-1:0]  SMIN     = -(SUM_W'(33'h0_8000_0000));

  logic [CNT_W-1:0]         n_cfg_r, n_r, lo_r, hi_r, xu_r, yu_r;
  logic                     axis_r;
  dp_op_t                   prev_op_r;
  logic [DCNT_W-1:0]        cnt_r;
  logic signed [DATA_W-1:0] x_r, y_r, a0_r, f00_r, fx1_r, fy1_r, slope_r, res_r;
  logic signed [DATA_W:0]   d_r, dx_r, dy_r;
  logic [DIV_W-1:0]         quo_r;
  logic [DATA_W+1:0]        rem_r;
  logic [DATA_W:0]          dvs_r;
  logic                     neg_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [TERM_W-1:0] tx_r, ty_r;
  logic signed [DATA_W-1:0] out_val_r;
  status_t                  out_st_r;

  logic [CNT_W:0]           mid_sum;
  logic [IDX_W-1:0]         mid, xl, yl, xh, yh, abs_raddr;
  logic [2*IDX_W-1:0]       grid_raddr;
  logic signed [DATA_W-1:0] abs_q, grid_q, coord, fsel;
  logic [CNT_W-1:0]         n_use;
  logic signed [DATA_W:0]   diff, dsel;
  logic [DATA_W:0]          diff_mag, d_mag;
  logic [DATA_W+1:0]        trial_sh;
  logic                     trial_ge;
  logic signed [DATA_W-1:0] slope_c;
  logic signed [PROD_W-1:0] prod_c, shifted;
  logic signed [TERM_W-1:0] term_c;
  logic signed [SUM_W-1:0]  sum_c;
  logic signed [DATA_W-1:0] res_c;

  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid     = mid_sum[IDX_W:1];
  assign coord   = axis_r ? y_r : x_r;
  assign xl      = IDX_W'(xu_r - CNT_W'(1));
  assign yl      = IDX_W'(yu_r - CNT_W'(1));
  assign xh      = (xu_r == n_r) ? xl : xu_r[IDX_W-1:0];
  assign yh      = (yu_r == n_r) ? yl : yu_r[IDX_W-1:0];

  always_comb begin
    abs_raddr  = mid;
    grid_raddr = {xl, yl};
    case (cmd.op)
      OP_RD_A0:  abs_raddr = '0;
      OP_RD_A1:  abs_raddr = IDX_W'(1);
      OP_RD_AXL: abs_raddr = xl;
      OP_RD_AYL: abs_raddr = yl;
      OP_RD_FX1: grid_raddr = {xh, yl};
      OP_RD_FY1: grid_raddr = {xl, yh};
      default:   abs_raddr = mid;
    endcase
  end

  gpi_ram #(.WIDTH(DATA_W), .DEPTH(GRID_POINTS)) u_abs_ram (
    .clk   (clk),
    .we    (cmd.op == OP_WR_ABS),
    .waddr (in_index_row),
    .wdata (in_write_value),
    .raddr (abs_raddr),
    .rdata (abs_q)
  );

  gpi_ram #(.WIDTH(DATA_W), .DEPTH(GRID_POINTS * GRID_POINTS)) u_grid_ram (
    .clk   (clk),
    .we    (cmd.op == OP_WR_GRID),
    .waddr ({in_index_row, in_index_col}),
    .wdata (in_write_value),
    .raddr (grid_raddr),
    .rdata (grid_q)
  );

  // divider operands: magnitudes, sign kept apart
  assign fsel     = cmd.axis ? fy1_r : fx1_r;
  assign diff     = {fsel[DATA_W-1], fsel} - {f00_r[DATA_W-1], f00_r};
  assign diff_mag = diff[DATA_W] ? DATA_W'(1) + (~diff) : diff;
  assign d_mag    = d_r[DATA_W] ? DATA_W'(1) + (~d_r) : d_r;
  assign trial_sh = {rem_r[DATA_W:0], quo_r[DIV_W-1]};
  assign trial_ge = trial_sh >= {1'b0, dvs_r};

  always_comb begin
    if (!neg_r) begin
      slope_c = (quo_r > POS_LIM) ? DATA_W'(32'h7FFF_FFFF) : quo_r[DATA_W-1:0];
    end else begin
      slope_c = (quo_r > NEG_LIM) ? DATA_W'(32'h8000_0000) : -quo_r[DATA_W-1:0];
    end
  end

  assign dsel    = cmd.axis ? dy_r : dx_r;
  assign prod_c  = slope_r * dsel;
  assign shifted = prod_r >>> FRAC_BITS;

  always_comb begin
    if (shifted > TLIM) begin
      term_c = TLIM[TERM_W-1:0];
    end else if (shifted < -TLIM) begin
      term_c = TERM_W'(-TLIM);
    end else begin
      term_c = shifted[TERM_W-1:0];
    end
  end

  assign sum_c = SUM_W'(f00_r) + SUM_W'(tx_r) + SUM_W'(ty_r);

  always_comb begin
    if (sum_c > SMAX) begin
      res_c = DATA_W'(32'h7FFF_FFFF);
    end else if (sum_c < SMIN) begin
      res_c = DATA_W'(32'h8000_0000);
    end else begin
      res_c = sum_c[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_cfg_r   <= CNT_W'(GRID_POINTS);
      prev_op_r <= OP_NONE;
      cnt_r     <= '0;
    end else begin
      prev_op_r <= cmd.op;
      if (cfg_wr_en) begin
        n_cfg_r <= cfg_wr_data;
      end
      if (cmd.op == OP_DIV_START) begin
        cnt_r <= DCNT_W'(DIV_W);
      end else if (cmd.op == OP_DIV_STEP) begin
        cnt_r <= cnt_r - DCNT_W'(1);
      end
    end
  end

  // clamp the used point count once per query
  always_comb begin
    if (n_cfg_r < CNT_W'(2)) begin
      n_use = CNT_W'(2);
    end else if (n_cfg_r > CNT_W'(GRID_POINTS)) begin
      n_use = CNT_W'(GRID_POINTS);
    end else begin
      n_use = n_cfg_r;
    end
  end

  always_ff @(posedge clk) begin
    // capture read data in the cycle after the read was issued
    case (prev_op_r)
      OP_SRCH_RD: begin
        if (coord < abs_q) begin
          hi_r <= CNT_W'(mid);
        end else begin
          lo_r <= CNT_W'(mid) + CNT_W'(1);
        end
      end
      OP_RD_A0:  a0_r <= abs_q;
      OP_RD_A1:  d_r  <= {abs_q[DATA_W-1], abs_q} - {a0_r[DATA_W-1], a0_r};
      OP_RD_AXL: dx_r <= {x_r[DATA_W-1], x_r} - {abs_q[DATA_W-1], abs_q};
      OP_RD_AYL: dy_r <= {y_r[DATA_W-1], y_r} - {abs_q[DATA_W-1], abs_q};
      OP_RD_F00: f00_r <= grid_q;
      OP_RD_FX1: fx1_r <= grid_q;
      OP_RD_FY1: fy1_r <= grid_q;
      default: ;
    endcase

    case (cmd.op)
      OP_LOAD: begin
        x_r    <= in_query_x;
        y_r    <= in_query_y;
        n_r    <= n_use;
        lo_r   <= '0;
        hi_r   <= n_use;
        axis_r <= 1'b0;
      end
      OP_SRCH_SAVE: begin
        if (axis_r) begin
          yu_r <= lo_r;
        end else begin
          xu_r <= lo_r;
        end
        lo_r   <= '0;
        hi_r   <= n_r;
        axis_r <= ~axis_r;
      end
      OP_DIV_START: begin
        quo_r <= {diff_mag, FRAC_BITS'(0)};
        rem_r <= '0;
        dvs_r <= d_mag;
        neg_r <= diff[DATA_W] ^ d_r[DATA_W];
      end
      OP_DIV_STEP: begin
        rem_r <= trial_ge ? trial_sh - {1'b0, dvs_r} : trial_sh;
        quo_r <= {quo_r[DIV_W-2:0], trial_ge};
      end
      OP_SAT:  slope_r <= slope_c;
      OP_MUL:  prod_r  <= prod_c;
      OP_TERM: begin
        if (cmd.axis) begin
          ty_r <= term_c;
        end else begin
          tx_r <= term_c;
        end
      end
      OP_SUM:  res_r <= res_c;
      OP_FINISH: begin
        out_val_r <= (cmd.code == ST_OK) ? res_r : '0;
        out_st_r  <= cmd.code;
      end
      default: ;
    endcase
  end

  assign stat.srch_done = lo_r >= hi_r;
  assign stat.srch_axis = axis_r;
  assign stat.below     = (xu_r == '0) || (yu_r == '0);
  assign stat.zero_d    = d_r == D0;
  assign stat.div_done  = cnt_r == '0;

  assign out_interpolated = out_val_r;
  assign out_status       = out_st_r;

  `GPI_ASSERT_IMPL(a_sat_after_div, cmd.op == OP_SAT, cnt_r == '0)
  `GPI_ASSERT_IMPL(a_save_converged, cmd.op == OP_SRCH_SAVE, lo_r == hi_r)
  `GPI_ASSERT_IMPL(a_step_in_range, cmd.op == OP_DIV_STEP, cnt_r != '0)

endmodule

/* src/gpi_ctrl.sv */
// Controller: sequences searches, table reads, division and result transfer.
`include "grid_plane_interpolator_core_assert.svh"
module gpi_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_cmd,
  output logic               out_valid,
  input  logic               out_ready,
  input  gpi_pkg::dp_stat_t  stat,
  output gpi_pkg::dp_cmd_t   cmd
);
  import gpi_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_SRCH, S_SWAIT, S_CHK, S_RA0, S_RA1, S_RAXL, S_RAYL,
    S_RF00, S_RFX1, S_RFY1, S_RLAST, S_CHKD, S_DIVS, S_DIVW,
    S_SAT, S_MUL, S_TERM, S_SUM, S_OUT
  } state_t;

  state_t  state_r, state_nxt;
  logic    ax_r, ax_nxt;
  status_t code_r, code_nxt;
  logic    out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    ax_nxt        = ax_r;
    code_nxt      = code_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.op        = OP_NONE;
    cmd.axis      = ax_r;
    cmd.code      = code_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (cmd_t'(in_cmd))
            CMD_WR_ABS:  cmd.op = OP_WR_ABS;
            CMD_WR_GRID: cmd.op = OP_WR_GRID;
            CMD_QUERY: begin
              cmd.op    = OP_LOAD;
              state_nxt = S_SRCH;
            end
            default: ;
          endcase
        end
      end
      S_SRCH: begin
        if (stat.srch_done) begin
          cmd.op = OP_SRCH_SAVE;
          if (stat.srch_axis) begin
            state_nxt = S_CHK;
          end
        end else begin
          cmd.op    = OP_SRCH_RD;
          state_nxt = S_SWAIT;
        end
      end
      S_SWAIT: state_nxt = S_SRCH;
      S_CHK: begin
        if (stat.below) begin
          code_nxt  = ST_BELOW;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_RA0;
        end
      end
      S_RA0: begin
        cmd.op    = OP_RD_A0;
        state_nxt = S_RA1;
      end
      S_RA1: begin
        cmd.op    = OP_RD_A1;
        state_nxt = S_RAXL;
      end
      S_RAXL: begin
        cmd.op    = OP_RD_AXL;
        state_nxt = S_RAYL;
      end
      S_RAYL: begin
        cmd.op    = OP_RD_AYL;
        state_nxt = S_RF00;
      end
      S_RF00: begin
        cmd.op    = OP_RD_F00;
        state_nxt = S_RFX1;
      end
      S_RFX1: begin
        cmd.op    = OP_RD_FX1;
        state_nxt = S_RFY1;
      end
      S_RFY1: begin
        cmd.op    = OP_RD_FY1;
        state_nxt = S_RLAST;
      end
      S_RLAST: state_nxt = S_CHKD;
      S_CHKD: begin
        ax_nxt = 1'b0;
        if (stat.zero_d) begin
          code_nxt  = ST_ZERO_D;
          state_nxt = S_OUT;
        end else begin
          code_nxt  = ST_OK;
          state_nxt = S_DIVS;
        end
      end
      S_DIVS: begin
        cmd.op    = OP_DIV_START;
        state_nxt = S_DIVW;
      end
      S_DIVW: begin
        if (stat.div_done) begin
          state_nxt = S_SAT;
        end else begin
          cmd.op = OP_DIV_STEP;
        end
      end
      S_SAT: begin
        cmd.op    = OP_SAT;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.op    = OP_MUL;
        state_nxt = S_TERM;
      end
      S_TERM: begin
        cmd.op = OP_TERM;
        if (ax_r) begin
          state_nxt = S_SUM;
        end else begin
          ax_nxt    = 1'b1;
          state_nxt = S_DIVS;
        end
      end
      S_SUM: begin
        cmd.op    = OP_SUM;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.op        = OP_FINISH;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ax_r        <= 1'b0;
      code_r      <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ax_r        <= ax_nxt;
      code_r      <= code_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;

  `GPI_ASSERT_IMPL(a_finish_free, cmd.op == OP_FINISH, !out_valid_r || out_ready)
  `GPI_ASSERT_NEXT(a_query_starts,
    in_valid && in_ready && in_cmd == CMD_QUERY, state_r == S_SRCH)
  `GPI_ASSERT_NEXT(a_finish_shows, cmd.op == OP_FINISH, out_valid_r && state_r == S_IDLE)

endmodule
